// File: sv/toric_correction_path_emitter_top_defines.svh
// Assertion macros for the toric correction path emitter.
// Used by modules that carry concurrent checks; needs no other file.
`ifndef TORIC_CORRECTION_PATH_EMITTER_TOP_DEFINES_SVH
`define TORIC_CORRECTION_PATH_EMITTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TCP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcp check failed");

// Next-cycle implication, disabled during reset.
`define TCP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcp check failed");

`endif

// File: sv/tcp_pkg.sv
// Shared widths, controller states and command/status structs for the
// toric correction path emitter. No dependencies.
`timescale 1ns / 1ps

package tcp_pkg;

  localparam int NODE_W    = 10;
  localparam int QUBIT_W   = 11;
  localparam int WIDTH_W   = 6;
  localparam int COORD_W   = 5;
  localparam int DIV_CNT_W = 3;
  localparam int SQ_W      = 2 * WIDTH_W;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 6'd8;
  localparam logic [WIDTH_W-1:0] WIDTH_MIN   = 6'd3;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH   = 6'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SETUP,
    ST_HWALK,
    ST_VWALK
  } tcp_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic setup;
    logic h_step;
    logic v_enter;
    logic v_step;
    logic emit;
    logic vertical;
  } tcp_cmd_t;

  typedef struct packed {
    logic drop;
    logic div_last;
    logic h_at_end;
    logic h_end_next;
    logic v_empty;
    logic v_last;
    logic slot_free;
  } tcp_status_t;

endpackage

// File: sv/tcp_pair_if.sv
// Input channel carrying one matched node pair per transaction.
// Depends on tcp_pkg for field widths.
`timescale 1ns / 1ps

interface tcp_pair_if;
  import tcp_pkg::*;

  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] first_node;
  logic [NODE_W-1:0] second_node;

  modport source (output valid, output first_node, output second_node, input ready);
  modport sink   (input valid, input first_node, input second_node, output ready);
endinterface

// File: sv/tcp_qubit_if.sv
// Output channel carrying one qubit index of a correction path per transaction.
// Depends on tcp_pkg for field widths.
`timescale 1ns / 1ps

interface tcp_qubit_if;
  import tcp_pkg::*;

  logic               valid;
  logic               ready;
  logic [QUBIT_W-1:0] qubit_index;
  logic               last_of_path;

  modport source (output valid, output qubit_index, output last_of_path, input ready);
  modport sink   (input valid, input qubit_index, input last_of_path, output ready);
endinterface

// File: sv/tcp_datapath.sv
// Datapath: lattice width register, restoring divider for node coordinates,
// walk position registers and the output register. Depends on tcp_pkg.
`timescale 1ns / 1ps

module tcp_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [tcp_pkg::WIDTH_W-1:0]   cfg_write_data,
  input  logic [tcp_pkg::NODE_W-1:0]    first_node,
  input  logic [tcp_pkg::NODE_W-1:0]    second_node,
  input  tcp_pkg::tcp_cmd_t             cmd,
  output tcp_pkg::tcp_status_t          status,
  output logic                          qubit_valid,
  input  logic                          qubit_ready,
  output logic [tcp_pkg::QUBIT_W-1:0]   qubit_index,
  output logic                          last_of_path
);
  import tcp_pkg::*;

  logic [WIDTH_W-1:0]   lattice_width;
  logic [SQ_W-1:0]      width_sq;
  logic [QUBIT_W-1:0]   cells_total;

  logic [NODE_W-1:0]    rem_a, rem_b;
  logic [COORD_W-1:0]   quot_a, quot_b;
  logic [DIV_CNT_W-1:0] div_bit;
  logic [QUBIT_W-1:0]   divisor_shift;

  logic [COORD_W-1:0]   ax, ay, bx, by;
  logic [COORD_W-1:0]   xmin, xmax, ymin, ymax, dx, dy;
  logic                 x_direct, y_direct;

  logic [COORD_W-1:0]   col, row, xe, ys, ye;
  logic [COORD_W-1:0]   col_next, row_next;
  logic [QUBIT_W-1:0]   row_base, h_index, v_index;

  assign width_sq    = lattice_width * lattice_width;
  assign cells_total = width_sq[QUBIT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      lattice_width <= WIDTH_RESET;
    end else if (cfg_write_en) begin
      if (cfg_write_data < WIDTH_MIN) begin
        lattice_width <= WIDTH_MIN;
      end else if (cfg_write_data > MAX_WIDTH) begin
        lattice_width <= MAX_WIDTH;
      end else begin
        lattice_width <= cfg_write_data;
      end
    end
  end

  assign status.drop = ({{(SQ_W-NODE_W){1'b0}}, first_node} >= width_sq) ||
                       ({{(SQ_W-NODE_W){1'b0}}, second_node} >= width_sq) ||
                       (first_node == second_node);

  assign divisor_shift = {{(QUBIT_W-WIDTH_W){1'b0}}, lattice_width} << div_bit;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_a   <= first_node;
      rem_b   <= second_node;
      quot_a  <= '0;
      quot_b  <= '0;
      div_bit <= DIV_CNT_W'(COORD_W - 1);
    end else if (cmd.div_step) begin
      if ({1'b0, rem_a} >= divisor_shift) begin
        rem_a          <= rem_a - divisor_shift[NODE_W-1:0];
        quot_a[div_bit] <= 1'b1;
      end
      if ({1'b0, rem_b} >= divisor_shift) begin
        rem_b          <= rem_b - divisor_shift[NODE_W-1:0];
        quot_b[div_bit] <= 1'b1;
      end
      div_bit <= div_bit - 1'b1;
    end
  end

  assign status.div_last = (div_bit == '0);

  assign ax = rem_a[COORD_W-1:0];
  assign bx = rem_b[COORD_W-1:0];
  assign ay = quot_a;
  assign by = quot_b;

  assign xmin = (ax < bx) ? ax : bx;
  assign xmax = (ax < bx) ? bx : ax;
  assign ymin = (ay < by) ? ay : by;
  assign ymax = (ay < by) ? by : ay;
  assign dx   = xmax - xmin;
  assign dy   = ymax - ymin;
  assign x_direct = ({dx, 1'b0} <= lattice_width);
  assign y_direct = ({dy, 1'b0} <= lattice_width);

  assign col_next = ({1'b0, col} == lattice_width - 1'b1) ? '0 : col + 1'b1;
  assign row_next = ({1'b0, row} == lattice_width - 1'b1) ? '0 : row + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      if (dx == '0) begin
        col <= ax;
        xe  <= ax;
        row <= ay;
      end else if (x_direct) begin
        col <= xmin;
        xe  <= xmax;
        row <= (ax < bx) ? ay : by;
      end else begin
        col <= xmax;
        xe  <= xmin;
        row <= (ax > bx) ? ay : by;
      end
      ys <= y_direct ? ymin : ymax;
      ye <= y_direct ? ymax : ymin;
    end else begin
      if (cmd.h_step) begin
        col <= col_next;
      end
      if (cmd.v_enter) begin
        row <= ys;
      end else if (cmd.v_step) begin
        row <= row_next;
      end
    end
  end

  assign status.h_at_end   = (col == xe);
  assign status.h_end_next = (col_next == xe);
  assign status.v_empty    = (ys == ye);
  assign status.v_last     = (row_next == ye);

  assign row_base = row * lattice_width;
  assign h_index  = row_base + {{(QUBIT_W-COORD_W){1'b0}}, col};
  assign v_index  = row_base + {{(QUBIT_W-COORD_W){1'b0}}, xe} + cells_total;

  assign status.slot_free = !qubit_valid || qubit_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      qubit_valid <= 1'b0;
    end else if (cmd.emit) begin
      qubit_valid <= 1'b1;
    end else if (qubit_ready) begin
      qubit_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.vertical) begin
        qubit_index  <= v_index;
        last_of_path <= (row_next == ye);
      end else begin
        qubit_index  <= h_index;
        last_of_path <= (col_next == xe) && (ys == ye);
      end
    end
  end

endmodule

// File: sv/tcp_ctrl.sv
// Controller state machine: pair intake, divide, setup and the two walk phases.
// Depends on tcp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "toric_correction_path_emitter_top_defines.svh"

module tcp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pair_valid,
  output logic                 pair_ready,
  input  tcp_pkg::tcp_status_t status,
  output tcp_pkg::tcp_cmd_t    cmd
);
  import tcp_pkg::*;

  tcp_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    pair_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        pair_ready = 1'b1;
        if (pair_valid) begin
          cmd.load = 1'b1;
          if (!status.drop) begin
            state_next = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_HWALK;
      end
      ST_HWALK: begin
        if (status.h_at_end) begin
          cmd.v_enter = 1'b1;
          state_next  = ST_VWALK;
        end else if (status.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.h_step = 1'b1;
          if (status.h_end_next) begin
            if (status.v_empty) begin
              state_next = ST_IDLE;
            end else begin
              cmd.v_enter = 1'b1;
              state_next  = ST_VWALK;
            end
          end
        end
      end
      ST_VWALK: begin
        if (status.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.vertical = 1'b1;
          cmd.v_step   = 1'b1;
          if (status.v_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `TCP_ASSERT_NOW(a_emit_has_slot, clk, rst, cmd.emit, status.slot_free)
  `TCP_ASSERT_NEXT(a_drop_stays_idle, clk, rst, state == ST_IDLE && pair_valid && status.drop, state == ST_IDLE)
  `TCP_ASSERT_NEXT(a_divide_to_setup, clk, rst, state == ST_DIVIDE && status.div_last, state == ST_SETUP)

endmodule

// File: sv/toric_correction_path_emitter_top.sv
// Sequence: a pair is taken at intake, then the divider yields one quotient bit per
// cycle for both nodes, then a setup step, one extra step when the x coordinates
// match, then one qubit per cycle while the output register has a free slot.
// Throughput: one pair at a time; a new pair is taken only once the last path is
// done, and the output register stalls the walk only.
// Reset: lattice_width returns to 8, the controller idles, the output empties.
`timescale 1ns / 1ps

module toric_correction_path_emitter_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [tcp_pkg::WIDTH_W-1:0] cfg_write_data,
  tcp_pair_if.sink                    pairs,
  tcp_qubit_if.source                 qubits
);
  import tcp_pkg::*;

  tcp_cmd_t    cmd;
  tcp_status_t status;

  tcp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (pairs.valid),
    .pair_ready (pairs.ready),
    .status     (status),
    .cmd        (cmd)
  );

  tcp_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .first_node     (pairs.first_node),
    .second_node    (pairs.second_node),
    .cmd            (cmd),
    .status         (status),
    .qubit_valid    (qubits.valid),
    .qubit_ready    (qubits.ready),
    .qubit_index    (qubits.qubit_index),
    .last_of_path   (qubits.last_of_path)
  );

endmodule
